// ----- rtl/ypc_pkg.sv -----
// shared types, constants and helper functions for the yaw/pitch camera pose block
`default_nettype none

package ypc_pkg;

   localparam int ANG_W    = 16;                  // binary angle, 65536 per turn
   localparam int VEC_W    = 16;                  // q1.15 vector component
   localparam int TRIG_W   = 17;                  // sin/cos in [-32768, 32768]
   localparam int POS_W    = 32;                  // q16.16 position
   localparam int CORDIC_W = 34;                  // q1.30 rotator with headroom
   localparam int ZACC_W   = 2 * ANG_W + 1;       // residual angle, 2^32 per turn
   localparam int SAT_IN_W = 24;                  // input width of the q1.15 clamp

   localparam int CORDIC_ITERS = 16;
   localparam int CORDIC_IW    = $clog2(CORDIC_ITERS);
   localparam int CORDIC_GAIN  = 652032874;
   localparam int Q15_ONE      = 32768;

   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_START_X = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_START_Y = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_START_Z = 2'd2;

   typedef enum logic [1:0] {
      OP_TURN  = 2'd0,
      OP_STEP  = 2'd1,
      OP_PLACE = 2'd2,
      OP_NONE  = 2'd3
   } ypc_op_type;

   // control from the sequencer to the vector unit
   typedef struct packed {
      logic       place;      // load start position
      logic       start;      // begin products and optional step
      logic       step;       // apply a step after the products
      logic [1:0] step_dir;   // bit 1 forward/right, bit 0 plus/minus
   } ypc_vec_ctl_type;

   // arctangent of 2^-i in units of 2^32 per turn
   function automatic logic signed [ZACC_W-1:0] atan_val(input logic [CORDIC_IW-1:0] i);
      logic signed [ZACC_W-1:0] a;
      case (i)
         4'd0:    a = 33'sd536870912;
         4'd1:    a = 33'sd316933406;
         4'd2:    a = 33'sd167458907;
         4'd3:    a = 33'sd85004756;
         4'd4:    a = 33'sd42667331;
         4'd5:    a = 33'sd21354465;
         4'd6:    a = 33'sd10679838;
         4'd7:    a = 33'sd5340245;
         4'd8:    a = 33'sd2670163;
         4'd9:    a = 33'sd1335087;
         4'd10:   a = 33'sd667544;
         4'd11:   a = 33'sd333772;
         4'd12:   a = 33'sd166886;
         4'd13:   a = 33'sd83443;
         4'd14:   a = 33'sd41722;
         4'd15:   a = 33'sd20861;
         default: a = '0;
      endcase
      return a;
   endfunction

   // q1.30 to q1.15, round half up, clamp to [-1.0, +1.0]
   function automatic logic signed [TRIG_W-1:0] to_q15(input logic signed [CORDIC_W-1:0] v);
      logic signed [CORDIC_W:0] r;
      r = (CORDIC_W+1)'(v) + (CORDIC_W+1)'(16384);
      r = r >>> 15;
      if (r > (CORDIC_W+1)'(Q15_ONE)) begin
         r = (CORDIC_W+1)'(Q15_ONE);
      end else if (r < (CORDIC_W+1)'(-Q15_ONE)) begin
         r = (CORDIC_W+1)'(-Q15_ONE);
      end
      return TRIG_W'(r);
   endfunction

   // clamp to a signed 16-bit component
   function automatic logic signed [VEC_W-1:0] sat16(input logic signed [SAT_IN_W-1:0] v);
      logic signed [VEC_W-1:0] r;
      if (v > SAT_IN_W'(32767)) begin
         r = 16'sd32767;
      end else if (v < SAT_IN_W'(-32768)) begin
         r = -16'sd32768;
      end else begin
         r = VEC_W'(v);
      end
      return r;
   endfunction

endpackage

`default_nettype wire

// ----- rtl/ypc_cordic.sv -----
// iterative rotation-mode cordic giving sine and cosine of a binary angle
`default_nettype none

module ypc_cordic
   import ypc_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic [ANG_W-1:0]         angle,
   output logic                     done,
   output logic signed [TRIG_W-1:0] sin_q,
   output logic signed [TRIG_W-1:0] cos_q
);

   typedef enum logic [1:0] {C_IDLE, C_ROT, C_FIN} cor_state_type;

   cor_state_type              state_ff, state_in;
   logic                       done_ff, done_in;
   logic [CORDIC_IW-1:0]       iter_ff, iter_in;
   logic                       flip_ff, flip_in;
   logic signed [CORDIC_W-1:0] x_ff, x_in, y_ff, y_in;
   logic signed [ZACC_W-1:0]   z_ff, z_in;
   logic signed [TRIG_W-1:0]   sin_ff, sin_in, cos_ff, cos_in;

   logic [ANG_W-1:0]           ang_fold;
   logic                       ang_flip;
   logic signed [CORDIC_W-1:0] x_sh, y_sh, x_fin, y_fin;

   // second and third quadrant: rotate by half a turn, negate at the end
   assign ang_flip = angle[ANG_W-1] ^ angle[ANG_W-2];
   assign ang_fold = angle ^ {ang_flip, {(ANG_W-1){1'b0}}};
   assign x_sh     = x_ff >>> iter_ff;
   assign y_sh     = y_ff >>> iter_ff;
   assign x_fin    = flip_ff ? -x_ff : x_ff;
   assign y_fin    = flip_ff ? -y_ff : y_ff;

   always_comb begin
      state_in = state_ff;
      done_in  = 1'b0;
      iter_in  = iter_ff;
      flip_in  = flip_ff;
      x_in     = x_ff;
      y_in     = y_ff;
      z_in     = z_ff;
      sin_in   = sin_ff;
      cos_in   = cos_ff;
      case (state_ff)
         C_IDLE: begin
            if (start) begin
               if (angle[ANG_W-3:0] == '0) begin
                  // exact quadrant angles
                  done_in = 1'b1;
                  case (angle[ANG_W-1:ANG_W-2])
                     2'd0: begin
                        sin_in = '0;
                        cos_in = TRIG_W'(Q15_ONE);
                     end
                     2'd1: begin
                        sin_in = TRIG_W'(Q15_ONE);
                        cos_in = '0;
                     end
                     2'd2: begin
                        sin_in = '0;
                        cos_in = TRIG_W'(-Q15_ONE);
                     end
                     default: begin
                        sin_in = TRIG_W'(-Q15_ONE);
                        cos_in = '0;
                     end
                  endcase
               end else begin
                  state_in = C_ROT;
                  iter_in  = '0;
                  flip_in  = ang_flip;
                  x_in     = CORDIC_W'(CORDIC_GAIN);
                  y_in     = '0;
                  z_in     = {ang_fold[ANG_W-1], ang_fold, {ANG_W{1'b0}}};
               end
            end
         end
         C_ROT: begin
            if (!z_ff[ZACC_W-1]) begin
               x_in = x_ff - y_sh;
               y_in = y_ff + x_sh;
               z_in = z_ff - atan_val(iter_ff);
            end else begin
               x_in = x_ff + y_sh;
               y_in = y_ff - x_sh;
               z_in = z_ff + atan_val(iter_ff);
            end
            iter_in = iter_ff + 1'b1;
            if (iter_ff == CORDIC_IW'(CORDIC_ITERS - 1)) begin
               state_in = C_FIN;
            end
         end
         C_FIN: begin
            sin_in   = to_q15(y_fin);
            cos_in   = to_q15(x_fin);
            done_in  = 1'b1;
            state_in = C_IDLE;
         end
         default: begin
            state_in = C_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= C_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      iter_ff <= iter_in;
      flip_ff <= flip_in;
      x_ff    <= x_in;
      y_ff    <= y_in;
      z_ff    <= z_in;
      sin_ff  <= sin_in;
      cos_ff  <= cos_in;
   end

   assign done  = done_ff;
   assign sin_q = sin_ff;
   assign cos_q = cos_ff;

endmodule

`default_nettype wire

// ----- rtl/ypc_vec.sv -----
// shared-multiplier unit: pose products, step delta and saturating position update
`default_nettype none

module ypc_vec
   import ypc_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  ypc_vec_ctl_type          ctl,
   input  logic signed [POS_W-1:0]  start_x,
   input  logic signed [POS_W-1:0]  start_y,
   input  logic signed [POS_W-1:0]  start_z,
   input  logic signed [TRIG_W-1:0] sin_yaw,
   input  logic signed [TRIG_W-1:0] cos_yaw,
   input  logic signed [TRIG_W-1:0] sin_pitch,
   input  logic signed [TRIG_W-1:0] cos_pitch,
   output logic                     done,
   output logic signed [VEC_W-1:0]  dir_x,
   output logic signed [VEC_W-1:0]  dir_y,
   output logic signed [VEC_W-1:0]  dir_z,
   output logic signed [VEC_W-1:0]  side_x,
   output logic signed [VEC_W-1:0]  side_z,
   output logic signed [VEC_W-1:0]  up_x,
   output logic signed [VEC_W-1:0]  up_y,
   output logic signed [VEC_W-1:0]  up_z,
   output logic signed [POS_W-1:0]  pos_x,
   output logic signed [POS_W-1:0]  pos_y,
   output logic signed [POS_W-1:0]  pos_z
);

   localparam int MA_W = 21;               // 24*v+5 and trig operands
   localparam int MB_W = 18;
   localparam int P_W  = MA_W + MB_W;
   localparam int R_W  = 24;
   localparam int RECIP_TEN  = 52429;      // 2^19 / 10, rounded up
   localparam int RECIP_SH   = 19;

   typedef enum logic [1:0] {V_IDLE, V_MUL, V_FORM, V_ACC} vec_state_type;

   vec_state_type            state_ff, state_in;
   logic [2:0]               op_ff, op_in;           // 0..3 products, 4..6 step axes
   logic                     step_ff, step_in;
   logic [1:0]               sd_ff, sd_in;
   logic                     done_ff, done_in;
   logic signed [P_W-1:0]    prod_ff, prod_in;
   logic signed [MA_W-1:0]   d_ff, d_in;
   logic signed [VEC_W-1:0]  fx_ff, fx_in, fz_ff, fz_in, ux_ff, ux_in, uz_ff, uz_in;
   logic signed [POS_W-1:0]  px_ff, px_in, py_ff, py_in, pz_ff, pz_in;

   logic signed [VEC_W-1:0]  fy_c, sx_c, sz_c, uy_c, v_sel;
   logic signed [MA_W-1:0]   t_c, ma, q_c, dq;
   logic signed [MB_W-1:0]   mb;
   logic signed [P_W-1:0]    rnd_c, qw_c;
   logic signed [R_W-1:0]    rem_c;
   logic signed [VEC_W-1:0]  m16;
   logic signed [POS_W-1:0]  p_sel, p_new;
   logic signed [POS_W:0]    p_sum;
   logic [1:0]               axis;

   assign fy_c = sat16(-(SAT_IN_W'(sin_pitch)));
   assign sx_c = sat16(SAT_IN_W'(cos_yaw));
   assign sz_c = sat16(-(SAT_IN_W'(sin_yaw)));
   assign uy_c = sat16(SAT_IN_W'(cos_pitch));

   assign axis = op_ff[1:0];

   // component of the step vector for this axis
   always_comb begin
      v_sel = '0;
      if (sd_ff[1]) begin
         case (axis)
            2'd0:    v_sel = fx_ff;
            2'd1:    v_sel = fy_c;
            default: v_sel = fz_ff;
         endcase
      end else begin
         case (axis)
            2'd0:    v_sel = sx_c;
            2'd1:    v_sel = '0;
            default: v_sel = sz_c;
         endcase
      end
   end

   assign t_c = (MA_W'(v_sel) <<< 4) + (MA_W'(v_sel) <<< 3) + MA_W'(5);

   // operand select for the shared multiplier
   always_comb begin
      case (op_ff)
         3'd0: begin
            ma = MA_W'(sin_yaw);
            mb = MB_W'(cos_pitch);
         end
         3'd1: begin
            ma = MA_W'(cos_yaw);
            mb = MB_W'(cos_pitch);
         end
         3'd2: begin
            ma = MA_W'(sin_pitch);
            mb = MB_W'(sin_yaw);
         end
         3'd3: begin
            ma = MA_W'(sin_pitch);
            mb = MB_W'(cos_yaw);
         end
         default: begin
            ma = t_c;
            mb = MB_W'(RECIP_TEN);
         end
      endcase
   end

   assign prod_in = ma * mb;

   // q1.15 product, round half up
   assign rnd_c = (prod_ff + P_W'(16384)) >>> 15;
   assign m16   = sat16(rnd_c[R_W-1:0]);

   // floor(t / 10): reciprocal estimate then one correction either way
   assign qw_c  = prod_ff >>> RECIP_SH;
   assign q_c   = qw_c[MA_W-1:0];
   assign rem_c = R_W'(t_c) - ((R_W'(q_c) <<< 3) + (R_W'(q_c) <<< 1));

   always_comb begin
      if (rem_c < 0) begin
         dq = q_c - MA_W'(1);
      end else if (rem_c >= R_W'(10)) begin
         dq = q_c + MA_W'(1);
      end else begin
         dq = q_c;
      end
   end

   always_comb begin
      case (axis)
         2'd0:    p_sel = px_ff;
         2'd1:    p_sel = py_ff;
         default: p_sel = pz_ff;
      endcase
   end

   assign p_sum = (POS_W+1)'(p_sel) + (POS_W+1)'(d_ff);

   always_comb begin
      if (p_sum > (POS_W+1)'(33'sd2147483647)) begin
         p_new = {1'b0, {(POS_W-1){1'b1}}};
      end else if (p_sum < (POS_W+1)'(-33'sd2147483648)) begin
         p_new = {1'b1, {(POS_W-1){1'b0}}};
      end else begin
         p_new = p_sum[POS_W-1:0];
      end
   end

   always_comb begin
      state_in = state_ff;
      op_in    = op_ff;
      step_in  = step_ff;
      sd_in    = sd_ff;
      done_in  = 1'b0;
      d_in     = d_ff;
      fx_in    = fx_ff;
      fz_in    = fz_ff;
      ux_in    = ux_ff;
      uz_in    = uz_ff;
      px_in    = px_ff;
      py_in    = py_ff;
      pz_in    = pz_ff;
      if (ctl.place) begin
         px_in = start_x;
         py_in = start_y;
         pz_in = start_z;
      end
      case (state_ff)
         V_IDLE: begin
            if (ctl.start) begin
               state_in = V_MUL;
               op_in    = '0;
               step_in  = ctl.step;
               sd_in    = ctl.step_dir;
            end
         end
         V_MUL: begin
            state_in = V_FORM;
         end
         V_FORM: begin
            if (!op_ff[2]) begin
               case (op_ff[1:0])
                  2'd0:    fx_in = m16;
                  2'd1:    fz_in = m16;
                  2'd2:    ux_in = m16;
                  default: uz_in = m16;
               endcase
               if (op_ff == 3'd3 && !step_ff) begin
                  state_in = V_IDLE;
                  done_in  = 1'b1;
               end else begin
                  state_in = V_MUL;
                  op_in    = op_ff + 1'b1;
               end
            end else begin
               d_in     = sd_ff[0] ? dq : -dq;
               state_in = V_ACC;
            end
         end
         V_ACC: begin
            case (axis)
               2'd0:    px_in = p_new;
               2'd1:    py_in = p_new;
               default: pz_in = p_new;
            endcase
            if (op_ff == 3'd6) begin
               state_in = V_IDLE;
               done_in  = 1'b1;
            end else begin
               state_in = V_MUL;
               op_in    = op_ff + 1'b1;
            end
         end
         default: begin
            state_in = V_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= V_IDLE;
         done_ff  <= 1'b0;
         px_ff    <= '0;
         py_ff    <= '0;
         pz_ff    <= '0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
         px_ff    <= px_in;
         py_ff    <= py_in;
         pz_ff    <= pz_in;
      end
      op_ff   <= op_in;
      step_ff <= step_in;
      sd_ff   <= sd_in;
      prod_ff <= prod_in;
      d_ff    <= d_in;
      fx_ff   <= fx_in;
      fz_ff   <= fz_in;
      ux_ff   <= ux_in;
      uz_ff   <= uz_in;
   end

   assign done   = done_ff;
   assign dir_x  = fx_ff;
   assign dir_y  = fy_c;
   assign dir_z  = fz_ff;
   assign side_x = sx_c;
   assign side_z = sz_c;
   assign up_x   = ux_ff;
   assign up_y   = uy_c;
   assign up_z   = uz_ff;
   assign pos_x  = px_ff;
   assign pos_y  = py_ff;
   assign pos_z  = pz_ff;

endmodule

`default_nettype wire

// ----- rtl/yaw_pitch_camera_pose.sv -----
// top level of the yaw/pitch camera pose tracker
//
//  channel  dir  transaction      payload
//  req_*    in   tvalid & tready  tuser: operation; tdata: yaw_turn, pitch_turn, step_dir
//  rsp_*    out  tvalid & tready  tdata: forward, right (x,z), up, position
//  csr_*    in   csr_we           start_x / start_y / start_z, no read-back
//
//  one transaction at a time: a new request waits until the response has been taken
//  one cordic pass for yaw, then one for pitch; an exact quadrant angle skips the rotation
//  the shared multiplier forms four products, then the three step axes when a step is requested
//  synchronous active-high reset clears angles, position and start registers
//  req_tready is high only while idle; a stalled result holds until rsp_tready
`default_nettype none

module yaw_pitch_camera_pose
   import ypc_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   // request
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [39:0]          req_tdata,   // yaw_turn[15:0], pitch_turn[31:16], step_dir[33:32]
   input  logic [1:0]           req_tuser,   // operation
   // response
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [223:0]         rsp_tdata,   // dir_x, dir_y, dir_z, side_x, side_z,
                                             // up_x, up_y, up_z, pos_x, pos_y, pos_z
   // configuration
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [POS_W-1:0]     csr_wdata
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_YAW_GO,
      S_YAW_RUN,
      S_PITCH_GO,
      S_PITCH_RUN,
      S_VEC_GO,
      S_VEC_RUN,
      S_OUT
   } top_state_type;

   top_state_type            state_ff, state_in;
   logic [ANG_W-1:0]         yaw_ff, yaw_in, pitch_ff, pitch_in;
   logic                     step_ff, step_in;
   logic [1:0]               sd_ff, sd_in;
   logic signed [TRIG_W-1:0] sy_ff, sy_in, cy_ff, cy_in, sp_ff, sp_in, cp_ff, cp_in;
   logic signed [POS_W-1:0]  start_x_ff, start_y_ff, start_z_ff;

   // request fields
   ypc_op_type               req_op;
   logic [ANG_W-1:0]         req_x_off, req_y_off;
   logic [1:0]               req_sd;
   logic                     req_fire;

   // cordic hookup
   logic                     cor_start, cor_done;
   logic [ANG_W-1:0]         cor_angle;
   logic signed [TRIG_W-1:0] cor_sin, cor_cos;

   // vector unit hookup
   ypc_vec_ctl_type          vctl;
   logic                     vec_done;
   logic signed [VEC_W-1:0]  dir_x, dir_y, dir_z, side_x, side_z, up_x, up_y, up_z;
   logic signed [POS_W-1:0]  pos_x, pos_y, pos_z;

   assign req_op    = ypc_op_type'(req_tuser);
   assign req_x_off = req_tdata[15:0];
   assign req_y_off = req_tdata[31:16];
   assign req_sd    = req_tdata[33:32];

   assign req_tready = (state_ff == S_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign rsp_tvalid = (state_ff == S_OUT);

   // start registers, writes past start_z fall through
   always_ff @(posedge clock) begin
      if (reset) begin
         start_x_ff <= '0;
         start_y_ff <= '0;
         start_z_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_START_X: start_x_ff <= csr_wdata;
            CSR_START_Y: start_y_ff <= csr_wdata;
            CSR_START_Z: start_z_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // sequencer: apply angle change, sin/cos of yaw, sin/cos of pitch, products and optional step, response
   always_comb begin
      state_in = state_ff;
      yaw_in   = yaw_ff;
      pitch_in = pitch_ff;
      step_in  = step_ff;
      sd_in    = sd_ff;
      sy_in    = sy_ff;
      cy_in    = cy_ff;
      sp_in    = sp_ff;
      cp_in    = cp_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               step_in  = 1'b0;
               sd_in    = req_sd;
               state_in = S_YAW_GO;
               case (req_op)
                  OP_TURN: begin
                     yaw_in   = yaw_ff - req_x_off;
                     pitch_in = pitch_ff + req_y_off;
                  end
                  OP_STEP: begin
                     step_in = 1'b1;
                  end
                  OP_PLACE: begin
                     yaw_in   = '0;
                     pitch_in = '0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_YAW_GO: begin
            state_in = S_YAW_RUN;
         end
         S_YAW_RUN: begin
            if (cor_done) begin
               sy_in    = cor_sin;
               cy_in    = cor_cos;
               state_in = S_PITCH_GO;
            end
         end
         S_PITCH_GO: begin
            state_in = S_PITCH_RUN;
         end
         S_PITCH_RUN: begin
            if (cor_done) begin
               sp_in    = cor_sin;
               cp_in    = cor_cos;
               state_in = S_VEC_GO;
            end
         end
         S_VEC_GO: begin
            state_in = S_VEC_RUN;
         end
         S_VEC_RUN: begin
            if (vec_done) begin
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (rsp_tready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         yaw_ff   <= '0;
         pitch_ff <= '0;
      end else begin
         state_ff <= state_in;
         yaw_ff   <= yaw_in;
         pitch_ff <= pitch_in;
      end
      step_ff <= step_in;
      sd_ff   <= sd_in;
      sy_ff   <= sy_in;
      cy_ff   <= cy_in;
      sp_ff   <= sp_in;
      cp_ff   <= cp_in;
   end

   assign cor_start = (state_ff == S_YAW_GO) || (state_ff == S_PITCH_GO);
   assign cor_angle = (state_ff == S_YAW_GO) ? yaw_ff : pitch_ff;

   ypc_cordic u_cordic (
      .clock (clock),
      .reset (reset),
      .start (cor_start),
      .angle (cor_angle),
      .done  (cor_done),
      .sin_q (cor_sin),
      .cos_q (cor_cos)
   );

   // place loads the position at acceptance; products start once both angles are done
   assign vctl.place    = req_fire && (req_op == OP_PLACE);
   assign vctl.start    = (state_ff == S_VEC_GO);
   assign vctl.step     = step_ff;
   assign vctl.step_dir = sd_ff;

   ypc_vec u_vec (
      .clock     (clock),
      .reset     (reset),
      .ctl       (vctl),
      .start_x   (start_x_ff),
      .start_y   (start_y_ff),
      .start_z   (start_z_ff),
      .sin_yaw   (sy_ff),
      .cos_yaw   (cy_ff),
      .sin_pitch (sp_ff),
      .cos_pitch (cp_ff),
      .done      (vec_done),
      .dir_x     (dir_x),
      .dir_y     (dir_y),
      .dir_z     (dir_z),
      .side_x    (side_x),
      .side_z    (side_z),
      .up_x      (up_x),
      .up_y      (up_y),
      .up_z      (up_z),
      .pos_x     (pos_x),
      .pos_y     (pos_y),
      .pos_z     (pos_z)
   );

   assign rsp_tdata = {pos_z, pos_y, pos_x, up_z, up_y, up_x, side_z, side_x,
                       dir_z, dir_y, dir_x};

   // a new request is never taken while a response is pending
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid))
      else $error("request accepted while response pending");

   // acceptance starts a busy period
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> !req_tready)
      else $error("still ready after accepting a request");

   // cordic finishes only while the sequencer waits on it
   a_cordic_done_window: assert property (@(posedge clock) disable iff (reset)
      cor_done |-> (state_ff == S_YAW_RUN || state_ff == S_PITCH_RUN))
      else $error("cordic done outside a cordic wait state");

   // vector unit finishes only while the sequencer waits on it
   a_vec_done_window: assert property (@(posedge clock) disable iff (reset)
      vec_done |-> (state_ff == S_VEC_RUN))
      else $error("vector unit done outside its wait state");

endmodule

`default_nettype wire
